// ===== hdl/rtcp_app_tlv_parser_defines.svh =====
// Assertion helpers shared by the parser blocks.
// Each check is sampled on the rising edge of clk and is off while rst is high.
`ifndef RTCP_APP_TLV_PARSER_DEFINES_SVH
`define RTCP_APP_TLV_PARSER_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define RTCP_CHECK_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// The property must hold in the cycle after the condition.
`define RTCP_CHECK_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/rtcp_tlv_pkg.sv =====
package rtcp_tlv_pkg;

  localparam logic [11:0] MAX_LEN     = 12'd2048;
  localparam logic [11:0] HDR_LEN     = 12'd12;
  localparam logic [7:0]  EXT_LEN_ID  = 8'd192;
  localparam logic [1:0]  VERSION_2   = 2'b10;
  localparam logic [9:0]  FIELD_MAX   = 10'd1023;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_NAME  = 3'd4;

  localparam logic [0:0] CFG_PKT_TYPE = 1'd0;
  localparam logic [0:0] CFG_APP_NAME = 1'd1;

  localparam logic [7:0]  RST_PKT_TYPE = 8'd204;
  localparam logic [31:0] RST_APP_NAME = 32'h4D43_5054;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [11:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  field_id;
    logic [7:0]  value_byte;
    logic [10:0] byte_index;
    logic        field_end;
    logic [2:0]  status;
    logic [4:0]  subtype;
    logic [31:0] sender_ssrc;
    logic [9:0]  field_count;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  pkt_type;
    logic [31:0] app_name;
  } cfg_regs_t;

  // Everything one input byte produces: an optional field result and an optional summary.
  typedef struct packed {
    logic        has_field;
    logic [1:0]  fkind;
    logic [7:0]  field_id;
    logic [7:0]  value_byte;
    logic [10:0] byte_index;
    logic        field_end;
    logic        has_sum;
    logic [2:0]  status;
    logic [4:0]  subtype;
    logic [31:0] ssrc;
    logic [9:0]  field_count;
  } step_rec_t;

endpackage

// ===== hdl/rtcp_tlv_parse.sv =====
`include "rtcp_app_tlv_parser_defines.svh"

module rtcp_tlv_parse import rtcp_tlv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output logic      push,
  output step_rec_t rec
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_LENHI  = 3'd2;
  localparam logic [2:0] PH_LENLO  = 3'd3;
  localparam logic [2:0] PH_VALUE  = 3'd4;
  localparam logic [2:0] PH_PAD    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  logic [11:0] pos, pos_next;
  logic [11:0] len_held, len_held_next;
  logic [2:0]  phase, phase_next;
  logic [2:0]  hstat, hstat_next;
  logic [4:0]  sub, sub_next;
  logic [31:0] ssrc, ssrc_next;
  logic [31:0] name, name_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [15:0] cur_len, cur_len_next;
  logic [10:0] val_cnt, val_cnt_next;
  logic [1:0]  pad_left, pad_left_next;
  logic [9:0]  fields, fields_next;

  always_comb begin
    logic [11:0] len_in;
    logic [11:0] p;
    logic [7:0]  b;
    logic        active;
    logic [1:0]  hdr;
    logic [15:0] cl;
    logic [11:0] vc_inc;
    logic [31:0] name_c;
    logic [1:0]  pad;

    b      = item.data_byte;
    len_in = (item.packet_length > MAX_LEN) ? MAX_LEN : item.packet_length;
    active = item.first_byte || (pos < len_held);
    cl     = 16'd0;
    vc_inc = 12'd0;
    name_c = 32'd0;
    pad    = 2'd0;

    pos_next      = pos;
    len_held_next = len_held;
    phase_next    = phase;
    hstat_next    = hstat;
    sub_next      = sub;
    ssrc_next     = ssrc;
    name_next     = name;
    cur_id_next   = cur_id;
    cur_len_next  = cur_len;
    val_cnt_next  = val_cnt;
    pad_left_next = pad_left;
    fields_next   = fields;

    rec = '0;

    if (item.first_byte) begin
      len_held_next = len_in;
      pos_next      = 12'd0;
      phase_next    = (len_in < HDR_LEN) ? PH_DONE : PH_HEADER;
      hstat_next    = (len_in < HDR_LEN) ? ST_SHORT : ST_OK;
      sub_next      = 5'd0;
      ssrc_next     = 32'd0;
      name_next     = 32'd0;
      cur_id_next   = 8'd0;
      cur_len_next  = 16'd0;
      val_cnt_next  = 11'd0;
      pad_left_next = 2'd0;
      fields_next   = 10'd0;
    end

    p   = pos_next;
    hdr = (cur_id_next >= EXT_LEN_ID) ? 2'd3 : 2'd2;

    if (active) begin
      case (phase_next)
        PH_HEADER: begin
          if (p == 12'd0) begin
            if (b[7:6] != VERSION_2 && hstat_next == ST_OK) hstat_next = ST_BAD_VER;
            sub_next = b[4:0];
          end else if (p == 12'd1) begin
            if (b != cfg.pkt_type && hstat_next == ST_OK) hstat_next = ST_BAD_TYPE;
          end else if (p >= 12'd4 && p <= 12'd7) begin
            ssrc_next = {ssrc_next[23:0], b};
          end else if (p >= 12'd8 && p <= 12'd11) begin
            name_c    = {name_next[23:0], b};
            name_next = name_c;
            if (p == 12'd11) begin
              if (name_c != cfg.app_name && hstat_next == ST_OK) hstat_next = ST_BAD_NAME;
              phase_next = (hstat_next == ST_OK) ? PH_ID : PH_DONE;
            end
          end
        end
        PH_ID: begin
          // An id needs room for its length bytes, or parsing stops for the rest of the packet.
          if ((13'(p) + 13'd2 > 13'(len_held_next)) ||
              (b >= EXT_LEN_ID && 13'(p) + 13'd3 > 13'(len_held_next))) begin
            phase_next = PH_DONE;
          end else begin
            cur_id_next  = b;
            cur_len_next = 16'd0;
            phase_next   = (b >= EXT_LEN_ID) ? PH_LENHI : PH_LENLO;
          end
        end
        PH_LENHI: begin
          cur_len_next = {b, 8'h00};
          phase_next   = PH_LENLO;
        end
        PH_LENLO: begin
          cl           = {cur_len_next[15:8], b};
          cur_len_next = cl;
          if (cur_id_next == 8'd0 && cl == 16'd0) begin
            phase_next = PH_DONE;
          end else if (17'(p) + 17'd1 + 17'(cl) > 17'(len_held_next)) begin
            phase_next = PH_DONE;
          end else begin
            if (fields_next != FIELD_MAX) fields_next = fields_next + 10'd1;
            val_cnt_next = 11'd0;
            if (cl == 16'd0) begin
              rec.has_field = 1'b1;
              rec.fkind     = KIND_EMPTY;
              rec.field_id  = cur_id_next;
              pad_left_next = 2'd0 - hdr;
              phase_next    = PH_PAD;
            end else begin
              phase_next = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          vc_inc         = {1'b0, val_cnt_next} + 12'd1;
          rec.has_field  = 1'b1;
          rec.fkind      = KIND_VALUE;
          rec.field_id   = cur_id_next;
          rec.value_byte = b;
          rec.byte_index = val_cnt_next;
          rec.field_end  = (16'(vc_inc) == cur_len_next);
          val_cnt_next   = vc_inc[10:0];
          if (16'(vc_inc) >= cur_len_next) begin
            pad           = 2'd0 - (hdr + cur_len_next[1:0]);
            pad_left_next = pad;
            phase_next    = (pad != 2'd0) ? PH_PAD : PH_ID;
          end
        end
        PH_PAD: begin
          if (pad_left_next != 2'd0) pad_left_next = pad_left_next - 2'd1;
          if (pad_left_next == 2'd0) phase_next = PH_ID;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      rec.has_sum = (13'(p) + 13'd1 >= 13'(len_held_next));
      rec.status  = hstat_next;
      if (hstat_next == ST_OK) begin
        rec.subtype     = sub_next;
        rec.ssrc        = ssrc_next;
        rec.field_count = fields_next;
      end
      pos_next = p + 12'd1;
    end

    push = step_en && active && (rec.has_field || rec.has_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 12'd0;
      len_held <= 12'd0;
      phase    <= PH_HEADER;
      hstat    <= ST_OK;
      sub      <= 5'd0;
      ssrc     <= 32'd0;
      name     <= 32'd0;
      cur_id   <= 8'd0;
      cur_len  <= 16'd0;
      val_cnt  <= 11'd0;
      pad_left <= 2'd0;
      fields   <= 10'd0;
    end else if (step_en) begin
      pos      <= pos_next;
      len_held <= len_held_next;
      phase    <= phase_next;
      hstat    <= hstat_next;
      sub      <= sub_next;
      ssrc     <= ssrc_next;
      name     <= name_next;
      cur_id   <= cur_id_next;
      cur_len  <= cur_len_next;
      val_cnt  <= val_cnt_next;
      pad_left <= pad_left_next;
      fields   <= fields_next;
    end
  end

  `RTCP_CHECK_IMPL(a_value_in_range, phase == PH_VALUE, 16'(val_cnt) < cur_len, "value counter past field length")
  `RTCP_CHECK_IMPL(a_pad_nonzero, phase == PH_PAD, pad_left != 2'd0, "pad phase with no pad bytes left")
  `RTCP_CHECK_NEXT(a_count_grows, step_en && !item.first_byte, fields >= $past(fields), "field count fell within a packet")

endmodule

// ===== hdl/rtcp_tlv_outq.sv =====
`include "rtcp_app_tlv_parser_defines.svh"

module rtcp_tlv_outq import rtcp_tlv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_rec_t rec,
  output logic      space_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  step_rec_t              mem [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueCntW-1:0]   count;
  logic                   half;
  logic                   pop;
  step_rec_t              head;

  assign head      = mem[rd_ptr];
  assign out_valid = (count != QueueCntW'(0));
  assign space_ok  = (count != QueueCntW'(QueueDepth));
  assign pop       = out_valid && out_ready && out_data.last_result;

  // A record holding both a field result and a summary goes out as two beats.
  always_comb begin
    out_data = '0;
    if (head.has_field && !half) begin
      out_data.kind        = head.fkind;
      out_data.field_id    = head.field_id;
      out_data.value_byte  = head.value_byte;
      out_data.byte_index  = head.byte_index;
      out_data.field_end   = head.field_end;
      out_data.last_result = !head.has_sum;
    end else begin
      out_data.kind        = KIND_SUMMARY;
      out_data.status      = head.status;
      out_data.subtype     = head.subtype;
      out_data.sender_ssrc = head.ssrc;
      out_data.field_count = head.field_count;
      out_data.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + QueuePtrW'(1);
      end
      count <= count + QueueCntW'(push) - QueueCntW'(pop);
      if (out_valid && out_ready) half <= !out_data.last_result;
    end
  end

  `RTCP_CHECK_IMPL(a_no_overflow, push, space_ok, "record pushed into a full queue")
  `RTCP_CHECK_IMPL(a_head_has_result, out_valid, head.has_field || head.has_sum, "queued record with no result")
  `RTCP_CHECK_IMPL(a_half_pair, out_valid && half, head.has_field && head.has_sum, "second beat on a single-result record")
  `RTCP_CHECK_NEXT(a_push_shows, push && !out_valid, out_valid, "pushed record not presented")

endmodule

// ===== hdl/rtcp_app_tlv_parser.sv =====
// Channel | Direction | Handshake             | Beat
// in      | input     | in_valid / in_ready   | one packet byte, first flag, packet length
// out     | output    | out_valid / out_ready | one field byte, empty marker or summary
// cfg     | input     | cfg_we                | packet type (index 0) or app name (index 1)
//
// One byte is accepted per cycle while in_ready is high; its results are queued.
// The last byte of a packet can yield a field result and a summary, sent as two beats.
// A four-record result queue decouples the sides; in_ready falls only when it is full.
// Reset is synchronous and active high; there is no clearing pass.
module rtcp_app_tlv_parser import rtcp_tlv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t cfg;
  logic      step_en;
  logic      push;
  step_rec_t rec;
  logic      space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pkt_type <= RST_PKT_TYPE;
      cfg.app_name <= RST_APP_NAME;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PKT_TYPE: cfg.pkt_type <= cfg_data[7:0];
        CFG_APP_NAME: cfg.app_name <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = space_ok;
  assign step_en  = in_valid && space_ok;

  rtcp_tlv_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (in_data),
    .cfg     (cfg),
    .push    (push),
    .rec     (rec)
  );

  rtcp_tlv_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rec       (rec),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/rtcp_app_tlv_parser_tb.sv =====
module rtcp_app_tlv_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtcp_tlv_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned PHASE_BYTES    = 230;

  typedef enum logic [2:0] {
    WALK_HEADER, WALK_ID, WALK_LEN_HI, WALK_LEN_LO, WALK_VALUE, WALK_PAD, WALK_DONE
  } walk_t;

  // Tracks the parser state per accepted byte and holds the results still owed by the block.
  class tlv_scoreboard;
    bit [7:0]    want_type = RST_PKT_TYPE;
    bit [31:0]   want_name = RST_APP_NAME;
    int unsigned pos, plen;
    walk_t       walk = WALK_HEADER;
    bit [2:0]    hstat;
    bit [4:0]    sub;
    bit [31:0]   ssrc, name_acc;
    bit [7:0]    fid;
    int unsigned flen, vcnt, pad_left, nfields;
    out_item_t   step_q[$];
    out_item_t   expected_q[$];
    int unsigned errors, n_values, n_empty;
    int unsigned n_status[5];

    static function int unsigned pad_to_word(int unsigned n);
      return (4 - n % 4) % 4;
    endfunction

    static function int unsigned head_bytes(bit [7:0] id);
      return (id >= EXT_LEN_ID) ? 3 : 2;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == CFG_PKT_TYPE) want_type = val[7:0];
      else want_name = val;
    endfunction

    function void push_result(bit [1:0] kind, bit [7:0] id, bit [7:0] vb,
                              int unsigned idx, bit fend);
      out_item_t r;
      r = '0;
      r.kind = kind;
      r.field_id = id;
      r.value_byte = vb;
      r.byte_index = idx[10:0];
      r.field_end = fend;
      if (kind == KIND_SUMMARY) begin
        r.status = hstat;
        if (hstat == ST_OK) begin
          r.subtype = sub;
          r.sender_ssrc = ssrc;
          r.field_count = nfields[9:0];
        end
      end
      step_q.insert(step_q.size(), r);
    endfunction

    function void walk_field(bit [7:0] b, int unsigned p, int unsigned len);
      case (walk)
        WALK_ID: begin
          if (p + 2 > len || (b >= EXT_LEN_ID && p + 3 > len)) begin
            walk = WALK_DONE;
          end else begin
            fid = b;
            flen = 0;
            walk = (b >= EXT_LEN_ID) ? WALK_LEN_HI : WALK_LEN_LO;
          end
        end
        WALK_LEN_HI: begin
          flen = 32'({b, 8'h00});
          walk = WALK_LEN_LO;
        end
        WALK_LEN_LO: begin
          flen = flen | 32'(b);
          if (fid == 0 && flen == 0) begin
            walk = WALK_DONE;
          end else if (p + 1 + flen > len) begin
            walk = WALK_DONE;
          end else begin
            if (nfields < FIELD_MAX) nfields++;
            vcnt = 0;
            if (flen == 0) begin
              push_result(KIND_EMPTY, fid, 8'h00, 0, 1'b0);
              pad_left = pad_to_word(head_bytes(fid));
              walk = (pad_left != 0) ? WALK_PAD : WALK_ID;
            end else begin
              walk = WALK_VALUE;
            end
          end
        end
        WALK_VALUE: begin
          push_result(KIND_VALUE, fid, b, vcnt, vcnt + 1 == flen);
          vcnt++;
          if (vcnt >= flen) begin
            pad_left = pad_to_word(head_bytes(fid) + flen);
            walk = (pad_left != 0) ? WALK_PAD : WALK_ID;
          end
        end
        WALK_PAD: begin
          if (pad_left > 0) pad_left--;
          if (pad_left == 0) walk = WALK_ID;
        end
        default: begin
          walk = WALK_DONE;
        end
      endcase
    endfunction

    function void note_input(in_item_t it);
      int unsigned p, len;
      bit [7:0] b;
      b = it.data_byte;
      step_q.delete();
      if (it.first_byte) begin
        len = 32'(it.packet_length);
        if (len > MAX_LEN) len = 32'(MAX_LEN);
        plen = len;
        pos = 0;
        walk = WALK_HEADER;
        hstat = ST_OK;
        sub = '0;
        ssrc = '0;
        name_acc = '0;
        fid = '0;
        flen = 0;
        vcnt = 0;
        pad_left = 0;
        nfields = 0;
        if (len < HDR_LEN) begin
          hstat = ST_SHORT;
          walk = WALK_DONE;
        end
      end else if (pos >= plen) begin
        return;
      end
      len = plen;
      p = pos;
      if (walk == WALK_HEADER) begin
        if (p == 0) begin
          if (b[7:6] != VERSION_2 && hstat == ST_OK) hstat = ST_BAD_VER;
          sub = b[4:0];
        end else if (p == 1) begin
          if (b != want_type && hstat == ST_OK) hstat = ST_BAD_TYPE;
        end else if (p >= 4 && p <= 7) begin
          ssrc = {ssrc[23:0], b};
        end else if (p >= 8 && p <= 11) begin
          name_acc = {name_acc[23:0], b};
          if (p == 11) begin
            if (name_acc != want_name && hstat == ST_OK) hstat = ST_BAD_NAME;
            walk = (hstat == ST_OK) ? WALK_ID : WALK_DONE;
          end
        end
      end else if (walk != WALK_DONE) begin
        walk_field(b, p, len);
      end
      if (p + 1 >= len) push_result(KIND_SUMMARY, 8'h00, 8'h00, 0, 1'b0);
      pos = p + 1;
      if (step_q.size() > 0) step_q[$].last_result = 1'b1;
      expected_q = {expected_q, step_q};
    endfunction

    function void diff_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result 0x%0h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        diff_field("kind", 32'(want.kind), 32'(got.kind));
        diff_field("field_id", 32'(want.field_id), 32'(got.field_id));
        diff_field("value_byte", 32'(want.value_byte), 32'(got.value_byte));
        diff_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
        diff_field("field_end", 32'(want.field_end), 32'(got.field_end));
        diff_field("status", 32'(want.status), 32'(got.status));
        diff_field("subtype", 32'(want.subtype), 32'(got.subtype));
        diff_field("sender_ssrc", want.sender_ssrc, got.sender_ssrc);
        diff_field("field_count", 32'(want.field_count), 32'(got.field_count));
        diff_field("last_result", 32'(want.last_result), 32'(got.last_result));
      end
      if (want.kind == KIND_VALUE) n_values++;
      else if (want.kind == KIND_EMPTY) n_empty++;
      else n_status[want.status]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  tlv_scoreboard sb;
  int unsigned   send_idle_pct, recv_stall_pct, hold_reqs;
  int unsigned   quiet_cycles, n_packets, n_bytes;
  bit [7:0]      pkt[$];
  bit [11:0]     pkt_declared;
  int unsigned   pkt_send_n, pkt_stray_n;

  rtcp_app_tlv_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // The receiver either holds off for a requested stretch or stalls at random.
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void add_byte(input bit [7:0] v);
    pkt.insert(pkt.size(), v);
  endfunction

  task automatic send_byte(input bit [7:0] b, input bit first, input bit [11:0] plen_f);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{data_byte: b, first_byte: first, packet_length: plen_f};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_send_n + pkt_stray_n; i++)
      send_byte(pkt[i], i == 0, (i == 0) ? pkt_declared : 12'($urandom));
    n_packets++;
    n_bytes += pkt_send_n + pkt_stray_n;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Lowers valid, waits for every owed result, then lets the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed packets with random fields; a minority carry header faults,
  // truncation, short or long declared lengths, restarts and stray bytes.
  task automatic make_packet();
    int unsigned n_fields, flen, total, eff, r, bit_sel, bad_at;
    bit [7:0]    hb, id;
    pkt.delete();
    r = $urandom_range(99);
    hb = {VERSION_2, 6'($urandom)};
    if (r < 6) hb[7:6] = hb[7:6] ^ 2'($urandom_range(1, 3));
    add_byte(hb);
    hb = sb.want_type;
    bit_sel = $urandom_range(0, 7);
    if (r >= 6 && r < 12) hb[bit_sel] = ~hb[bit_sel];
    add_byte(hb);
    repeat (6) add_byte(8'($urandom));
    bad_at = $urandom_range(0, 3);
    for (int i = 3; i >= 0; i--) begin
      hb = sb.want_name[8*i +: 8];
      if (r >= 12 && r < 18 && i == bad_at) hb[bit_sel] = ~hb[bit_sel];
      add_byte(hb);
    end

    n_fields = $urandom_range(0, 4);
    repeat (n_fields) begin
      r = $urandom_range(99);
      if (r < 8) id = 8'd0;
      else if (r < 65) id = 8'($urandom_range(1, 191));
      else id = 8'($urandom_range(192, 255));
      r = $urandom_range(99);
      if (r < 15) flen = 0;
      else if (r < 90) flen = $urandom_range(1, 8);
      else if (id < EXT_LEN_ID) flen = $urandom_range(9, 255);
      else flen = $urandom_range(9, 300);
      add_byte(id);
      if (id >= EXT_LEN_ID) add_byte(flen[15:8]);
      add_byte(flen[7:0]);
      repeat (flen) add_byte(8'($urandom));
      repeat (tlv_scoreboard::pad_to_word(tlv_scoreboard::head_bytes(id) + flen))
        add_byte(8'($urandom));
    end
    if ($urandom_range(99) < 15) begin
      add_byte(8'h00);
      add_byte(8'h00);
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
    end

    total = pkt.size();
    r = $urandom_range(99);
    if (r < 8) pkt_declared = 12'($urandom_range(0, HDR_LEN - 1));
    else if (r < 20 && total > HDR_LEN) pkt_declared = 12'($urandom_range(HDR_LEN, total - 1));
    else if (r < 30) pkt_declared = 12'(total + $urandom_range(1, 6));
    else pkt_declared = 12'(total);

    eff = 32'(pkt_declared);
    pkt_send_n = (eff == 0) ? 1 : eff;
    pkt_stray_n = 0;
    r = $urandom_range(99);
    if (r < 8 && pkt_send_n > 1) pkt_send_n = $urandom_range(1, pkt_send_n - 1);
    else if (r < 18) pkt_stray_n = $urandom_range(1, 3);
    while (pkt.size() < pkt_send_n + pkt_stray_n) add_byte(8'($urandom));
  endtask

  initial begin
    bit [7:0]  phase_type[4];
    bit [31:0] phase_name[4];
    int unsigned phase_send_idle[4];
    int unsigned phase_recv_stall[4];
    int unsigned start_bytes;

    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PKT_TYPE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Stray byte before any packet, zero length, short length, clipped length cut short
    // by a restart, a minimal good packet with an empty extended-length field, and a long
    // field that fits the declared length but not the clipped one.
    send_byte(8'hA5, 1'b0, 12'hFFF);
    send_byte(8'h80, 1'b1, 12'h000);
    pkt = '{8'hFF, 8'h00, 8'h5A};
    pkt_declared = 12'd3;
    pkt_send_n = 3;
    pkt_stray_n = 0;
    send_packet();
    send_byte(8'h80, 1'b1, 12'hFFF);
    send_byte(8'hCC, 1'b0, 12'h000);
    pkt = '{8'h9F, RST_PKT_TYPE, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            RST_APP_NAME[31:24], RST_APP_NAME[23:16], RST_APP_NAME[15:8], RST_APP_NAME[7:0],
            8'hFF, 8'h00, 8'h00, 8'hFF};
    pkt_declared = 12'd16;
    pkt_send_n = 16;
    send_packet();
    pkt = '{8'h81, RST_PKT_TYPE, 8'h00, 8'h05, 8'h12, 8'h34, 8'h56, 8'h78,
            RST_APP_NAME[31:24], RST_APP_NAME[23:16], RST_APP_NAME[15:8], RST_APP_NAME[7:0],
            8'hC0, 8'h07, 8'hF8, 8'h11, 8'h22, 8'h33, 8'h44};
    pkt_declared = 12'hFFF;
    pkt_send_n = 19;
    send_packet();
    drain();

    phase_type = '{8'h00, 8'hFF, 8'($urandom), RST_PKT_TYPE};
    phase_name = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, RST_APP_NAME};
    phase_send_idle = '{0, 48, 0, 13};
    phase_recv_stall = '{0, 0, 48, 13};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_PKT_TYPE, {24'h0, phase_type[ph]});
      write_reg(CFG_APP_NAME, phase_name[ph]);
      send_idle_pct = phase_send_idle[ph];
      recv_stall_pct = phase_recv_stall[ph];
      // A long hold-off on the output lets the result queue fill and stall the input.
      if (ph == 0) hold_reqs++;
      start_bytes = n_bytes;
      while (n_bytes - start_bytes < PHASE_BYTES) begin
        make_packet();
        send_packet();
      end
      drain();
    end

    $display("Covered %0d packets, %0d bytes, four handshake phases and four register settings.",
             n_packets, n_bytes);
    $display("Results: %0d value bytes, %0d empty fields, summaries ok/short/ver/type/name %0d/%0d/%0d/%0d/%0d.",
             sb.n_values, sb.n_empty, sb.n_status[0], sb.n_status[1], sb.n_status[2],
             sb.n_status[3], sb.n_status[4]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
